FILE: sv/cdvn_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cdvn_pkg
// Shared constants, register indexes and hash helpers for the cloud density
// value noise block.
// ============================================================================
package cdvn_pkg;

   // Default lattice fraction width.
   localparam int CDVN_FRAC_BITS = 16;

   // Operand width of the shared signed multiplier.
   localparam int CDVN_MUL_W = 34;

   // Configuration port widths.
   localparam int CDVN_CSR_IDX_W  = 4;
   localparam int CDVN_CSR_DATA_W = 32;

   // Configuration register indexes.
   localparam logic [CDVN_CSR_IDX_W-1:0] CSR_WIND_X = 4'd0;
   localparam logic [CDVN_CSR_IDX_W-1:0] CSR_WIND_Z = 4'd1;
   localparam logic [CDVN_CSR_IDX_W-1:0] CSR_SCALE  = 4'd2;
   localparam logic [CDVN_CSR_IDX_W-1:0] CSR_SEED   = 4'd3;

   // Register reset values.
   localparam logic [23:0] WIND_X_RESET = 24'd131072;
   localparam logic [23:0] WIND_Z_RESET = 24'd39322;
   localparam logic [23:0] SCALE_RESET  = 24'd349525;
   localparam logic [31:0] SEED_RESET   = 32'd1;
   localparam logic [16:0] COVER_RESET  = 17'd26214;

   // Request kinds.
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Hash constants.
   localparam logic [31:0] HASH_MUL_X = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
   localparam logic [31:0] HASH_MUL_S = 32'd362437;
   localparam logic [31:0] HASH_MIX   = 32'd1274126177;
   localparam logic [31:0] OCT2_SEED_ADD = 32'd7;

   // Octave and density constants.
   localparam logic [17:0] OCT2_MUL    = 18'd150733;
   localparam logic [15:0] WEIGHT_LO   = 16'd42598;
   localparam logic [15:0] WEIGHT_HI   = 16'd22938;
   localparam logic [16:0] COVER_BASE  = 17'd22938;
   localparam logic [15:0] COVER_SPAN  = 16'd36044;
   localparam logic [15:0] THRESH_BASE = 16'd49152;
   localparam logic [15:0] BAND_WIDTH  = 16'd13107;
   localparam logic [16:0] ONE_Q16     = 17'd65536;

   // First mixing step of the corner hash, ahead of the multiply.
   function automatic logic [31:0] hash_premix(input logic [31:0] h);
      return h ^ (h >> 13);
   endfunction

   // Final folding step of the corner hash, 24 bits kept.
   function automatic logic [23:0] hash_fold(input logic [31:0] h);
      logic [31:0] f;
      f = h ^ (h >> 16);
      return f[23:0];
   endfunction

endpackage

FILE: sv/cdvn_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// cdvn_mul
// Shared signed multiplier with a registered product. Every multiply of the
// block goes through this unit, one product per cycle.
// ============================================================================
module cdvn_mul #(
   parameter int OP_W = cdvn_pkg::CDVN_MUL_W
) (
   input  logic                     clock,
   input  logic signed [OP_W-1:0]   op_a,
   input  logic signed [OP_W-1:0]   op_b,
   output logic signed [2*OP_W-1:0] product
);

   logic signed [2*OP_W-1:0] product_ff;

   // Product register: result is available in the cycle after the operands.
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

FILE: sv/cloud_density_value_noise.sv
`timescale 1ns / 1ps
// ============================================================================
// cloud_density_value_noise
// Tick and density query engine: wind scroll, coverage, and two octaves of
// hashed 2-D value noise mapped through a clamped smoothstep.
// ============================================================================
// One transaction is handled at a time. A density query first forms the
// second-octave scale, then runs each octave in turn, then does the weighting
// and the final fade, and last presents the result. The single shared
// multiplier serves every coordinate scale, fade, corner hash and blend in
// turn. A finished result waits in the output register until taken; the next
// request is accepted as soon as the result has moved there.
module cloud_density_value_noise #(
   parameter int FRAC_BITS = cdvn_pkg::CDVN_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [31:0]                   req_world_x,
   input  logic signed [31:0]                   req_world_z,
   input  logic signed [23:0]                   req_time_step,
   input  logic signed [23:0]                   req_wetness_level,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [16:0]                          rsp_density,
   output logic                                 rsp_was_query,
   // Configuration port
   input  logic                                 csr_write,
   input  logic [cdvn_pkg::CDVN_CSR_IDX_W-1:0]  csr_index,
   input  logic [cdvn_pkg::CDVN_CSR_DATA_W-1:0] csr_wdata
);

   import cdvn_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int MW = CDVN_MUL_W;
   localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
   localparam logic [17:0]  THREE_ONE_Q16 = 18'd196608;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_TICK   = 6'b000010,
      ST_KPREP  = 6'b000100,
      ST_OCT    = 6'b001000,
      ST_WEIGHT = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       oct_ff, oct_in;

   // Configuration and persistent state
   logic signed [23:0] wind_x_ff, wind_z_ff;
   logic [23:0]        scale_ff;
   logic [31:0]        seed_ff;
   logic [39:0]        drift_x_ff, drift_z_ff;
   logic [16:0]        cover_ff;

   // Per-transaction working registers
   logic               is_query_ff;
   logic signed [32:0] px_ff, pz_ff;
   logic [23:0]        dt_ff;
   logic [16:0]        wet_ff;
   logic [25:0]        k2_ff;
   logic [31:0]        ix_ff, iz_ff, hx_ff, hy_ff, hsum_ff;
   logic [F-1:0]       fx_ff, fz_ff;
   logic [F:0]         tx_ff, tz_ff;
   logic [F-1:0]       ca_ff, cb_ff, cc_ff, cd_ff, e0_ff, e1_ff, n1_ff, n2_ff;
   logic [F+16:0]      acc_ff;
   logic [16:0]        tb_ff, res_ff;

   // Output register
   logic        rsp_valid_ff;
   logic [16:0] rsp_density_ff;
   logic        rsp_was_query_ff;

   // Multiplier connection
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod;

   // Derived values
   logic         accept;
   logic         out_load;
   logic [25:0]  k_sel;
   logic [31:0]  seed_sel;
   logic [31:0]  corner_h;
   logic [23:0]  fold_h;
   logic [F:0]   diff_ba, diff_dc, diff_e;
   logic [F+16:0] wsum;
   logic [F-1:0] n_val;
   logic [F+15:0] n_wide;
   logic [15:0]  n16, thr;
   logic signed [17:0] band_diff;
   logic [16:0]  band_t;
   logic [41:0]  round_k2;
   logic [31:0]  round_cov;
   logic [16:0]  wet_clamp;

   cdvn_mul #(.OP_W(MW)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign k_sel    = oct_ff ? k2_ff : {2'b00, scale_ff};
   assign seed_sel = oct_ff ? (seed_ff + OCT2_SEED_ADD) : seed_ff;

   // Corner order: (0,0), (1,0), (0,1), (1,1) on steps 10 to 13.
   always_comb begin
      corner_h = hsum_ff;
      case (step_ff)
         5'd11:   corner_h = hsum_ff + HASH_MUL_X;
         5'd12:   corner_h = hsum_ff + HASH_MUL_Y;
         5'd13:   corner_h = hsum_ff + HASH_MUL_X + HASH_MUL_Y;
         default: corner_h = hsum_ff;
      endcase
   end

   // Folded hash of the product that leaves the multiplier.
   assign fold_h = hash_fold(prod[31:0]);

   assign diff_ba = {1'b0, cb_ff} - {1'b0, ca_ff};
   assign diff_dc = {1'b0, cd_ff} - {1'b0, cc_ff};
   assign diff_e  = {1'b0, e1_ff} - {1'b0, e0_ff};

   // Octave weighting, rescale to Q0.16 and band position.
   assign wsum      = acc_ff + prod[F+16:0];
   assign n_val     = wsum[F+15:16];
   assign n_wide    = {n_val, 16'h0000};
   assign n16       = n_wide[F +: 16];
   assign thr       = THRESH_BASE - {1'b0, cover_ff[15:1]};
   assign band_diff = $signed({2'b00, n16}) - $signed({2'b00, thr});
   always_comb begin
      if (band_diff <= 18'sd0) begin
         band_t = 17'd0;
      end else if (band_diff >= $signed({2'b00, BAND_WIDTH})) begin
         band_t = ONE_Q16;
      end else begin
         // The band is 13107 wide and 5 * 13107 = 65535, so the scaled
         // quotient is exactly five times the offset.
         band_t = {band_diff[14:0], 2'b00} + {2'b00, band_diff[14:0]};
      end
   end

   assign round_k2  = prod[41:0] + 42'd32768;
   assign round_cov = prod[31:0] + 32'd32768;

   // Wetness clamped to the range 0 to 1.0.
   always_comb begin
      if (req_wetness_level < 24'sd0) begin
         wet_clamp = 17'd0;
      end else if (req_wetness_level > 24'sd65536) begin
         wet_clamp = ONE_Q16;
      end else begin
         wet_clamp = req_wetness_level[16:0];
      end
   end

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_TICK: begin
            case (step_ff)
               5'd0: begin
                  mul_a = MW'(wind_x_ff);
                  mul_b = {{(MW-24){1'b0}}, dt_ff};
               end
               5'd1: begin
                  mul_a = MW'(wind_z_ff);
                  mul_b = {{(MW-24){1'b0}}, dt_ff};
               end
               5'd2: begin
                  mul_a = {{(MW-16){1'b0}}, COVER_SPAN};
                  mul_b = {{(MW-17){1'b0}}, wet_ff};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_KPREP: begin
            mul_a = {{(MW-24){1'b0}}, scale_ff};
            mul_b = {{(MW-18){1'b0}}, OCT2_MUL};
         end
         ST_OCT: begin
            case (step_ff)
               5'd0: begin
                  mul_a = MW'(px_ff);
                  mul_b = {{(MW-26){1'b0}}, k_sel};
               end
               5'd1: begin
                  mul_a = MW'(pz_ff);
                  mul_b = {{(MW-26){1'b0}}, k_sel};
               end
               5'd2: begin
                  mul_a = {{(MW-F){1'b0}}, fx_ff};
                  mul_b = {{(MW-F){1'b0}}, fx_ff};
               end
               5'd3: begin
                  mul_a = {{(MW-F){1'b0}}, prod[2*F-1:F]};
                  mul_b = {{(MW-F-2){1'b0}}, THREE_ONE - {1'b0, fx_ff, 1'b0}};
               end
               5'd4: begin
                  mul_a = {{(MW-F){1'b0}}, fz_ff};
                  mul_b = {{(MW-F){1'b0}}, fz_ff};
               end
               5'd5: begin
                  mul_a = {{(MW-F){1'b0}}, prod[2*F-1:F]};
                  mul_b = {{(MW-F-2){1'b0}}, THREE_ONE - {1'b0, fz_ff, 1'b0}};
               end
               5'd6: begin
                  mul_a = {2'b00, ix_ff};
                  mul_b = {2'b00, HASH_MUL_X};
               end
               5'd7: begin
                  mul_a = {2'b00, iz_ff};
                  mul_b = {2'b00, HASH_MUL_Y};
               end
               5'd8: begin
                  mul_a = {2'b00, seed_sel};
                  mul_b = {2'b00, HASH_MUL_S};
               end
               5'd10, 5'd11, 5'd12, 5'd13: begin
                  mul_a = {2'b00, hash_premix(corner_h)};
                  mul_b = {2'b00, HASH_MIX};
               end
               5'd14: begin
                  mul_a = {{(MW-F-1){diff_ba[F]}}, diff_ba};
                  mul_b = {{(MW-F-1){1'b0}}, tx_ff};
               end
               5'd15: begin
                  mul_a = {{(MW-F-1){diff_dc[F]}}, diff_dc};
                  mul_b = {{(MW-F-1){1'b0}}, tx_ff};
               end
               5'd17: begin
                  mul_a = {{(MW-F-1){diff_e[F]}}, diff_e};
                  mul_b = {{(MW-F-1){1'b0}}, tz_ff};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_WEIGHT: begin
            case (step_ff)
               5'd0: begin
                  mul_a = {{(MW-F){1'b0}}, n1_ff};
                  mul_b = {{(MW-16){1'b0}}, WEIGHT_LO};
               end
               5'd1: begin
                  mul_a = {{(MW-F){1'b0}}, n2_ff};
                  mul_b = {{(MW-16){1'b0}}, WEIGHT_HI};
               end
               5'd3: begin
                  mul_a = {{(MW-17){1'b0}}, tb_ff};
                  mul_b = {{(MW-17){1'b0}}, tb_ff};
               end
               5'd4: begin
                  mul_a = {{(MW-17){1'b0}}, prod[32:16]};
                  mul_b = {{(MW-18){1'b0}}, THREE_ONE_Q16 - {tb_ff, 1'b0}};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 5'd1;
      oct_in   = oct_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = 5'd0;
            oct_in  = 1'b0;
            if (accept) begin
               state_in = (req_type == REQ_QUERY) ? ST_KPREP : ST_TICK;
            end
         end
         ST_TICK: begin
            if (step_ff == 5'd3) begin
               state_in = ST_OUT;
            end
         end
         ST_KPREP: begin
            step_in  = 5'd0;
            state_in = ST_OCT;
         end
         ST_OCT: begin
            if (step_ff == 5'd18) begin
               step_in = 5'd0;
               if (oct_ff) begin
                  state_in = ST_WEIGHT;
               end else begin
                  oct_in = 1'b1;
               end
            end
         end
         ST_WEIGHT: begin
            if (step_ff == 5'd5) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            step_in = 5'd0;
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = 5'd0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 5'd0;
         oct_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         oct_ff   <= oct_in;
      end
   end

   // Configuration registers and persistent tick state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wind_x_ff   <= WIND_X_RESET;
         wind_z_ff   <= WIND_Z_RESET;
         scale_ff    <= SCALE_RESET;
         seed_ff     <= SEED_RESET;
         drift_x_ff  <= '0;
         drift_z_ff  <= '0;
         cover_ff    <= COVER_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIND_X: wind_x_ff <= csr_wdata[23:0];
               CSR_WIND_Z: wind_z_ff <= csr_wdata[23:0];
               CSR_SCALE:  scale_ff  <= csr_wdata[23:0];
               CSR_SEED:   seed_ff   <= (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
               default:    ;
            endcase
         end
         if (state_ff == ST_TICK) begin
            case (step_ff)
               5'd1:    drift_x_ff <= drift_x_ff + prod[55:16];
               5'd2:    drift_z_ff <= drift_z_ff + prod[55:16];
               5'd3:    cover_ff   <= COVER_BASE + {1'b0, round_cov[31:16]};
               default: ;
            endcase
         end
      end
   end

   // Datapath registers: transaction capture and per-step results.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_query_ff <= req_type;
         px_ff  <= 33'(req_world_x) + 33'($signed(drift_x_ff[39:8]));
         pz_ff  <= 33'(req_world_z) + 33'($signed(drift_z_ff[39:8]));
         dt_ff  <= req_time_step[23] ? 24'd0 : req_time_step;
         wet_ff <= wet_clamp;
      end
      if (state_ff == ST_TICK) begin
         res_ff <= 17'd0;
      end
      if (state_ff == ST_OCT) begin
         case (step_ff)
            5'd0: begin
               if (!oct_ff) begin
                  k2_ff <= round_k2[41:16];
               end
            end
            5'd1: begin
               ix_ff <= prod[63:32];
               fx_ff <= prod[31:32-F];
            end
            5'd2: begin
               iz_ff <= prod[63:32];
               fz_ff <= prod[31:32-F];
            end
            5'd4:  tx_ff   <= prod[2*F:F];
            5'd6:  tz_ff   <= prod[2*F:F];
            5'd7:  hx_ff   <= prod[31:0];
            5'd8:  hy_ff   <= prod[31:0];
            5'd9:  hsum_ff <= hx_ff + hy_ff + prod[31:0];
            5'd11: ca_ff   <= fold_h[23 -: F];
            5'd12: cb_ff   <= fold_h[23 -: F];
            5'd13: cc_ff   <= fold_h[23 -: F];
            5'd14: cd_ff   <= fold_h[23 -: F];
            5'd15: e0_ff   <= ca_ff + prod[2*F-1:F];
            5'd16: e1_ff   <= cc_ff + prod[2*F-1:F];
            5'd18: begin
               if (oct_ff) begin
                  n2_ff <= e0_ff + prod[2*F-1:F];
               end else begin
                  n1_ff <= e0_ff + prod[2*F-1:F];
               end
            end
            default: ;
         endcase
      end
      if (state_ff == ST_WEIGHT) begin
         case (step_ff)
            5'd1:    acc_ff <= prod[F+16:0];
            5'd2:    tb_ff  <= band_t;
            5'd5:    res_ff <= prod[32:16];
            default: ;
         endcase
      end
   end

   // Output register: holds a result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_density_ff   <= res_ff;
         rsp_was_query_ff <= is_query_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_density   = rsp_density_ff;
   assign rsp_was_query = rsp_was_query_ff;

   // A request transaction always starts a busy period.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted without entering busy state");

   // Tick results carry zero density.
   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_query) |-> (rsp_density == 17'd0))
      else $error("tick result with nonzero density");

   // Density never exceeds 1.0.
   a_density_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_density <= ONE_Q16))
      else $error("density above 1.0");

   // Coverage stays between its base and base plus span.
   a_cover_range: assert property (@(posedge clock) disable iff (reset)
      (cover_ff >= COVER_BASE) && (cover_ff <= 17'd58982))
      else $error("coverage out of range");

endmodule

FILE: tb/tb_cloud_density_value_noise.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_cloud_density_value_noise
// Self-checking testbench for the cloud density value noise block. Ticks and
// density queries are driven in random bursts while the result side stalls on
// its own pattern. An in-bench model of the wind scroll, the coverage and the
// two noise octaves predicts every result, and each returned transaction is
// compared field by field. The registers are rewritten between phases.
// ============================================================================
module tb_cloud_density_value_noise;
   import cdvn_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [CDVN_CSR_IDX_W-1:0] CSR_UNMAPPED_A = 4'd4;
   localparam logic [CDVN_CSR_IDX_W-1:0] CSR_UNMAPPED_B = 4'd15;

   typedef struct {
      logic               kind;
      logic signed [31:0] wx;
      logic signed [31:0] wz;
      logic signed [23:0] dt;
      logic signed [23:0] wet;
   } cloud_req_type;

   typedef struct {
      logic [16:0] density;
      logic        was_query;
   } cloud_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = REQ_TICK;
   logic signed [31:0] req_world_x = '0;
   logic signed [31:0] req_world_z = '0;
   logic signed [23:0] req_time_step = '0;
   logic signed [23:0] req_wetness_level = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [16:0] rsp_density;
   logic rsp_was_query;
   logic csr_write = 1'b0;
   logic [CDVN_CSR_IDX_W-1:0] csr_index = '0;
   logic [CDVN_CSR_DATA_W-1:0] csr_wdata = '0;

   cloud_density_value_noise u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_world_x(req_world_x), .req_world_z(req_world_z),
      .req_time_step(req_time_step), .req_wetness_level(req_wetness_level),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_density(rsp_density), .rsp_was_query(rsp_was_query),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the block's registers and state.
   logic signed [23:0] wind_x;
   logic signed [23:0] wind_z;
   logic [23:0]        cell_scale;
   logic [31:0]        hash_seed;
   logic signed [39:0] drift_x;
   logic signed [39:0] drift_z;
   longint             coverage;

   cloud_req_type pending_reqs[$];
   cloud_rsp_type expected_rsps[$];
   int mismatches = 0;
   int ticks_checked = 0;
   int queries_checked = 0;
   bit calm_sender = 1'b0;

   // Smoothstep t*t*(3-2t) in Q.16, flooring each product.
   function automatic longint smooth_q16(input longint t);
      longint t2;
      t2 = (t * t) >>> 16;
      return (t2 * (196608 - 2 * t)) >>> 16;
   endfunction

   // Lattice corner value: 24-bit hash reduced to a Q.16 level.
   function automatic longint corner_level(input logic [31:0] x, input logic [31:0] z,
                                           input logic [31:0] s);
      logic [31:0] h;
      h = x * HASH_MUL_X + z * HASH_MUL_Y + s * HASH_MUL_S;
      h = (h ^ (h >> 13)) * HASH_MIX;
      h = h ^ (h >> 16);
      return longint'(h[23:8]);
   endfunction

   function automatic longint lerp_q16(input longint a, input longint b, input longint t);
      return a + (((b - a) * t) >>> 16);
   endfunction

   // One octave of value noise at lattice coordinates in Q32.16.
   function automatic longint octave_noise(input longint cx, input longint cz,
                                           input logic [31:0] s);
      logic [31:0] ix;
      logic [31:0] iz;
      longint tx;
      longint tz;
      ix = 32'(cx >>> 16);
      iz = 32'(cz >>> 16);
      tx = smooth_q16(cx & 64'hFFFF);
      tz = smooth_q16(cz & 64'hFFFF);
      return lerp_q16(lerp_q16(corner_level(ix, iz, s), corner_level(ix + 32'd1, iz, s), tx),
                      lerp_q16(corner_level(ix, iz + 32'd1, s),
                               corner_level(ix + 32'd1, iz + 32'd1, s), tx), tz);
   endfunction

   function automatic longint cloud_density(input longint wx, input longint wz);
      longint px, pz, k1, k2, n1, n2, n, diff, t;
      px = wx + (longint'(drift_x) >>> 8);
      pz = wz + (longint'(drift_z) >>> 8);
      k1 = longint'(cell_scale);
      k2 = (k1 * 150733 + 32768) >>> 16;
      n1 = octave_noise((px * k1) >>> 16, (pz * k1) >>> 16, hash_seed);
      n2 = octave_noise((px * k2) >>> 16, (pz * k2) >>> 16, hash_seed + OCT2_SEED_ADD);
      n = (n1 * 42598 + n2 * 22938) >>> 16;
      diff = n - (49152 - (coverage >>> 1));
      if (diff <= 0) t = 0;
      else if (diff >= 13107) t = 65536;
      else t = (diff <<< 16) / 13107;
      return smooth_q16(t);
   endfunction

   // Advance the shadow state by one accepted transaction; queue its result.
   function automatic void predict_transaction(input cloud_req_type r);
      cloud_rsp_type e;
      longint dt, w;
      if (r.kind == REQ_TICK) begin
         dt = longint'(r.dt);
         w = longint'(r.wet);
         if (dt < 0) dt = 0;
         drift_x = drift_x + 40'((longint'(wind_x) * dt) >>> 16);
         drift_z = drift_z + 40'((longint'(wind_z) * dt) >>> 16);
         if (w < 0) w = 0;
         if (w > 65536) w = 65536;
         coverage = 22938 + ((36044 * w + 32768) >>> 16);
         e.density = '0;
         e.was_query = 1'b0;
      end else begin
         e.density = 17'(cloud_density(longint'(r.wx), longint'(r.wz)));
         e.was_query = 1'b1;
      end
      expected_rsps.push_back(e);
   endfunction

   // Request driver: bursts of back-to-back transactions with random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      cloud_req_type nxt;
      logic drive_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_valid = req_valid;
         if (req_valid && !req_stall) begin
            predict_transaction('{req_type, req_world_x, req_world_z,
                                   req_time_step, req_wetness_level});
            drive_valid = 1'b0;
         end
         if (!drive_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_type <= nxt.kind;
               req_world_x <= nxt.wx;
               req_world_z <= nxt.wz;
               req_time_step <= nxt.dt;
               req_wetness_level <= nxt.wet;
               drive_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = calm_sender ? 0 : $urandom_range(0, 9);
               end
            end
         end
         req_valid <= drive_valid;
      end
   end

   // Result stall pattern: the phase counter redraws one of four stall modes at random.
   int stall_mode = 0;
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ((stall_phase % 16) < 11);
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Result monitor and stall watchdog.
   int idle_cycles = 0;
   always @(posedge clock) begin
      cloud_rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result transaction: density %0d was_query %0d",
                           rsp_density, rsp_was_query);
            end else begin
               e = expected_rsps.pop_front();
               if (e.was_query) queries_checked++;
               else ticks_checked++;
               if (rsp_density !== e.density || rsp_was_query !== e.was_query) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: density exp %0d got %0d, was_query exp %0d got %0d",
                              e.density, rsp_density, e.was_query, rsp_was_query);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Register write; the shadow copy is updated alongside.
   task automatic write_reg(input logic [CDVN_CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_WIND_X: wind_x = val[23:0];
         CSR_WIND_Z: wind_z = val[23:0];
         CSR_SCALE:  cell_scale = val[23:0];
         CSR_SEED:   hash_seed = (val == 32'd0) ? 32'd1 : val;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_tick(input logic signed [23:0] dt, input logic signed [23:0] wet);
      pending_reqs.push_back('{REQ_TICK, 32'sd0, 32'sd0, dt, wet});
   endtask

   task automatic add_query(input logic signed [31:0] wx, input logic signed [31:0] wz);
      pending_reqs.push_back('{REQ_QUERY, wx, wz, 24'($urandom), 24'($urandom)});
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly queries near the origin, some anywhere, some ticks.
   task automatic add_random(input int count);
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 3)
            add_tick(($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20000)),
                     ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65536)));
         else if (sel < 5)
            add_query(32'($urandom), 32'($urandom));
         else
            add_query(32'($urandom_range(0, 400000)) - 32'sd200000,
                      32'($urandom_range(0, 400000)) - 32'sd200000);
      end
   endtask

   initial begin
      wind_x = WIND_X_RESET;
      wind_z = WIND_Z_RESET;
      cell_scale = SCALE_RESET;
      hash_seed = SEED_RESET;
      drift_x = '0;
      drift_z = '0;
      coverage = longint'(COVER_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, clamps and negative steps at reset settings.
      add_query(32'sd0, 32'sd0);
      add_query(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      add_query(32'sh80000000, 32'sh80000000);
      add_query(32'sh80000000, 32'sh7FFFFFFF);
      add_tick(-24'sd1, -24'sd5);
      add_query(32'sd12345, -32'sd9876);
      add_tick(24'sh7FFFFF, 24'sh7FFFFF);
      add_query(32'sd4000, 32'sd4000);
      add_tick(24'sh800000, 24'sd65536);
      add_query(-32'sd4000, 32'sd70000);
      add_tick(24'sd65536, 24'sd32768);
      add_query(32'sd100, 32'sd200);
      add_tick(24'sd0, 24'sd0);
      add_query(32'sd3000, -32'sd3000);
      add_tick(24'sd1000, 24'sd65535);
      add_query(32'sd50000, 32'sd50000);
      add_query(32'sd1, 32'sd1);
      add_tick(24'sd1, 24'sd65537);
      add_query(-32'sd1, -32'sd1);
      drain();

      // Extreme settings; long ticks push the scroll past its 40-bit range.
      write_reg(CSR_WIND_X, 32'h007FFFFF);
      write_reg(CSR_WIND_Z, 32'hFF800000);
      write_reg(CSR_SCALE, 32'h00FFFFFF);
      write_reg(CSR_SEED, 32'd0);
      write_reg(CSR_UNMAPPED_A, 32'hDEADBEEF);
      write_reg(CSR_UNMAPPED_B, 32'h12345678);
      calm_sender = 1'b1;
      for (int i = 0; i < 560; i++) begin
         add_tick(24'sh7FFFFF, 24'($urandom_range(0, 65536)));
         if (i % 14 == 0) add_query(32'($urandom), 32'($urandom));
      end
      drain();

      // Random phases under different settings.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_reg(CSR_SCALE, 32'd0);
               write_reg(CSR_SEED, 32'hFFFFFFFF);
            end
            1: begin
               write_reg(CSR_SCALE, 32'd1);
               write_reg(CSR_WIND_X, 32'h00800000);
               write_reg(CSR_WIND_Z, 32'h007FFFFF);
            end
            default: begin
               write_reg(CSR_WIND_X, $urandom);
               write_reg(CSR_WIND_Z, $urandom);
               write_reg(CSR_SCALE, $urandom_range(20000, 3000000));
               write_reg(CSR_SEED, $urandom);
            end
         endcase
         calm_sender = (p == 2);
         add_random(150);
         drain();
      end

      $display("Checked %0d tick and %0d query results over extreme and random settings.",
               ticks_checked, queries_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
